FILE: hw/rtl/rlsl_pkg.sv
// shared constants, types and state codes for the radial light splat lightmap
`default_nettype none

package rlsl_pkg;

  localparam int MAP_WIDTH  = 256;
  localparam int MAP_HEIGHT = 256;
  localparam int TEXELS     = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W     = $clog2(TEXELS);

  // root of a 48-bit radicand and quotient of (1 - d) in Q1.16, which reaches 1.0
  localparam int SQRT_W = 24;
  localparam int QUO_W  = 17;

  // cycles waited after the last texel is issued, longer than the texel pipeline
  localparam int DRAIN_W = 6;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
  } tag_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_RCAP,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rlsl_sweep.sv
// texel scan generator and squared distance test against the light radius
`default_nettype none

module rlsl_sweep import rlsl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] center_x,
  input  logic [15:0] center_y,
  input  logic [15:0] radius,
  output logic        busy,
  output tag_t        tag_out,
  output logic [31:0] dist2
);

  localparam int XW = $clog2(MAP_WIDTH);
  localparam int YW = $clog2(MAP_HEIGHT);
  localparam int INIT_QX = 32768 / MAP_WIDTH;
  localparam int INIT_RX = 32768 % MAP_WIDTH;
  localparam int STEP_QX = 65536 / MAP_WIDTH;
  localparam int STEP_RX = 65536 % MAP_WIDTH;
  localparam int INIT_QY = 32768 / MAP_HEIGHT;
  localparam int INIT_RY = 32768 % MAP_HEIGHT;
  localparam int STEP_QY = 65536 / MAP_HEIGHT;
  localparam int STEP_RY = 65536 % MAP_HEIGHT;

  logic              active;
  logic [XW-1:0]     xi;
  logic [YW-1:0]     yi;
  logic [ADDR_W-1:0] addr;
  logic [15:0]       tx_q, ty_q;
  logic [XW-1:0]     tx_r;
  logic [YW-1:0]     ty_r;
  logic [15:0]       cx, cy;
  logic [31:0]       r2;

  logic [XW:0]       rx_sum;
  logic [YW:0]       ry_sum;

  tag_t              t1, t2, t3;
  logic [15:0]       dx, dy;
  logic [31:0]       sqx, sqy;
  logic [32:0]       d2_sum;

  // texel centre follows (2i+1)*32768/side as quotient and remainder
  assign rx_sum = {1'b0, tx_r} + (XW+1)'(STEP_RX);
  assign ry_sum = {1'b0, ty_r} + (YW+1)'(STEP_RY);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      xi     <= '0;
      yi     <= '0;
      addr   <= '0;
      tx_q   <= 16'(INIT_QX);
      tx_r   <= XW'(INIT_RX);
      ty_q   <= 16'(INIT_QY);
      ty_r   <= YW'(INIT_RY);
      cx     <= center_x;
      cy     <= center_y;
      r2     <= radius * radius;
    end else if (active) begin
      addr <= addr + 1'b1;
      if (xi == XW'(MAP_WIDTH - 1)) begin
        xi   <= '0;
        tx_q <= 16'(INIT_QX);
        tx_r <= XW'(INIT_RX);
        if (yi == YW'(MAP_HEIGHT - 1)) begin
          active <= 1'b0;
        end else begin
          yi <= yi + 1'b1;
          if (ry_sum >= (YW+1)'(MAP_HEIGHT)) begin
            ty_r <= YW'(ry_sum - (YW+1)'(MAP_HEIGHT));
            ty_q <= ty_q + 16'(STEP_QY) + 16'd1;
          end else begin
            ty_r <= ry_sum[YW-1:0];
            ty_q <= ty_q + 16'(STEP_QY);
          end
        end
      end else begin
        xi <= xi + 1'b1;
        if (rx_sum >= (XW+1)'(MAP_WIDTH)) begin
          tx_r <= XW'(rx_sum - (XW+1)'(MAP_WIDTH));
          tx_q <= tx_q + 16'(STEP_QX) + 16'd1;
        end else begin
          tx_r <= rx_sum[XW-1:0];
          tx_q <= tx_q + 16'(STEP_QX);
        end
      end
    end
  end

  assign d2_sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.vld <= 1'b0;
      t2.vld <= 1'b0;
      t3.vld <= 1'b0;
    end else begin
      t1.vld  <= active;
      t1.addr <= addr;
      dx      <= (tx_q >= cx) ? tx_q - cx : cx - tx_q;
      dy      <= (ty_q >= cy) ? ty_q - cy : cy - ty_q;
      t2      <= t1;
      sqx     <= dx * dx;
      sqy     <= dy * dy;
      // texels outside the radius drop out here
      t3.vld  <= t2.vld && (d2_sum < {1'b0, r2});
      t3.addr <= t2.addr;
      dist2   <= d2_sum[31:0];
    end
  end

  assign busy    = active;
  assign tag_out = t3;

endmodule

`default_nettype wire

FILE: hw/rtl/rlsl_sqrt.sv
// pipelined integer square root of dist2 * 2^16, one root bit per stage
`default_nettype none

module rlsl_sqrt import rlsl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tag_t              tag_in,
  input  logic [31:0]       dist2,
  output tag_t              tag_out,
  output logic [SQRT_W-1:0] root
);

  localparam int RAD_W = 2 * SQRT_W;
  localparam int REM_W = SQRT_W + 2;

  tag_t              in_tag  [SQRT_W];
  logic [REM_W-1:0]  in_rem  [SQRT_W];
  logic [SQRT_W-1:0] in_root [SQRT_W];
  logic [RAD_W-1:0]  in_rad  [SQRT_W];

  logic [REM_W-1:0]  nx_rem  [SQRT_W];
  logic [SQRT_W-1:0] nx_root [SQRT_W];
  logic [RAD_W-1:0]  nx_rad  [SQRT_W];

  tag_t              s_tag   [SQRT_W];
  logic [REM_W-1:0]  s_rem   [SQRT_W];
  logic [SQRT_W-1:0] s_root  [SQRT_W];
  logic [RAD_W-1:0]  s_rad   [SQRT_W];

  assign in_tag[0]  = tag_in;
  assign in_rem[0]  = '0;
  assign in_root[0] = '0;
  assign in_rad[0]  = {dist2, 16'b0};

  for (genvar k = 0; k < SQRT_W; k++) begin : g_step
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    logic             ge;
    if (k > 0) begin : g_link
      assign in_tag[k]  = s_tag[k-1];
      assign in_rem[k]  = s_rem[k-1];
      assign in_root[k] = s_root[k-1];
      assign in_rad[k]  = s_rad[k-1];
    end
    assign rs         = {in_rem[k][REM_W-3:0], in_rad[k][RAD_W-1:RAD_W-2]};
    assign trial      = {in_root[k], 2'b01};
    assign ge         = rs >= trial;
    assign nx_rem[k]  = ge ? rs - trial : rs;
    assign nx_root[k] = {in_root[k][SQRT_W-2:0], ge};
    assign nx_rad[k]  = {in_rad[k][RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_W; k++) begin
        s_tag[k].vld <= 1'b0;
      end
    end else begin
      for (int k = 0; k < SQRT_W; k++) begin
        s_tag[k]  <= in_tag[k];
        s_rem[k]  <= nx_rem[k];
        s_root[k] <= nx_root[k];
        s_rad[k]  <= nx_rad[k];
      end
    end
  end

  assign tag_out = s_tag[SQRT_W-1];
  assign root    = s_root[SQRT_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/rlsl_div.sv
// pipelined restoring divider giving (1 - d) in Q1.16 as ((r<<8) - dist) * 256 / r
`default_nettype none

module rlsl_div import rlsl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tag_t              tag_in,
  input  logic [SQRT_W-1:0] dist_root,
  input  logic [15:0]       divisor,
  output tag_t              tag_out,
  output logic [QUO_W-1:0]  quo
);

  tag_t              t0;
  logic [31:0]       num;

  tag_t              in_tag  [QUO_W];
  logic [15:0]       in_rem  [QUO_W];
  logic [QUO_W-1:0]  in_q    [QUO_W];
  logic [QUO_W-1:0]  in_bits [QUO_W];

  logic [15:0]       nx_rem  [QUO_W];

  tag_t              s_tag   [QUO_W];
  logic [15:0]       s_rem   [QUO_W];
  logic [QUO_W-1:0]  s_q     [QUO_W];
  logic [QUO_W-1:0]  s_bits  [QUO_W];

  logic              ge      [QUO_W];

  // the quotient never exceeds 2^16, so the top bits of the numerator start below r
  assign in_tag[0]  = t0;
  assign in_rem[0]  = {1'b0, num[31:QUO_W]};
  assign in_q[0]    = '0;
  assign in_bits[0] = num[QUO_W-1:0];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [16:0] rs;
    logic [16:0] diff;
    if (k > 0) begin : g_link
      assign in_tag[k]  = s_tag[k-1];
      assign in_rem[k]  = s_rem[k-1];
      assign in_q[k]    = s_q[k-1];
      assign in_bits[k] = s_bits[k-1];
    end
    assign rs        = {in_rem[k], in_bits[k][QUO_W-1]};
    assign diff      = rs - {1'b0, divisor};
    assign ge[k]     = rs >= {1'b0, divisor};
    assign nx_rem[k] = ge[k] ? diff[15:0] : rs[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0.vld <= 1'b0;
      for (int k = 0; k < QUO_W; k++) begin
        s_tag[k].vld <= 1'b0;
      end
    end else begin
      t0  <= tag_in;
      num <= {({divisor, 8'b0} - dist_root), 8'b0};
      for (int k = 0; k < QUO_W; k++) begin
        s_tag[k]  <= in_tag[k];
        s_rem[k]  <= nx_rem[k];
        s_q[k]    <= {in_q[k][QUO_W-2:0], ge[k]};
        s_bits[k] <= {in_bits[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  assign tag_out = s_tag[QUO_W-1];
  assign quo     = s_q[QUO_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/rlsl_lmem.sv
// lightmap memory with the falloff multiply and rounded, saturating read-modify-write
`default_nettype none

module rlsl_lmem import rlsl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tag_t              tag_in,
  input  logic [QUO_W-1:0]  v,
  input  logic [8:0]        strength,
  input  logic              clr_en,
  input  logic [ADDR_W-1:0] clr_addr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]        mem [TEXELS];
  logic [7:0]        rdata;

  tag_t              t1, t2, t3;
  logic [33:0]       vv;
  logic [41:0]       p;
  logic [49:0]       p255;
  logic [9:0]        hi;
  logic              half, sticky;

  logic [10:0]       q;
  logic [10:0]       q_round;
  logic [7:0]        new_level;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wd;
  logic [ADDR_W-1:0] ra;

  assign p255 = {p, 8'b0} - {8'b0, p};

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.vld <= 1'b0;
      t2.vld <= 1'b0;
      t3.vld <= 1'b0;
    end else begin
      t1     <= tag_in;
      vv     <= v * v;
      t2     <= t1;
      p      <= vv[32:0] * strength;
      t3     <= t2;
      hi     <= p255[49:40];
      half   <= p255[39];
      sticky <= |p255[38:0];
    end
  end

  // add the integer part, then round half to even on the 40 fraction bits
  assign q         = {3'b0, rdata} + {1'b0, hi};
  assign q_round   = q + {10'b0, half & (sticky | q[0])};
  assign new_level = (q_round > 11'd255) ? 8'd255 : q_round[7:0];

  assign we = clr_en | t3.vld;
  assign wa = clr_en ? clr_addr : t3.addr;
  assign wd = clr_en ? 8'd0 : new_level;
  assign ra = rd_en ? rd_addr : t2.addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[ra];
  end

  assign rd_data = rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/radial_light_splat_lightmap.sv
// top level: control sequencer for the lightmap, light splat pipeline and result register
// Request channel (req_valid / req_stall) carries one operation per transaction:
//   operation = add light: centre, radius (0 counts as 1) and strength splat into the map
//   operation = read: level of texel_index, 0 when the index is past the map
// Response channel (rsp_valid / rsp_stall) returns exactly one transaction per request:
//   level and was_read = 1 for a read, level 0 and was_read = 0 for a finished splat.
// After reset the map is cleared by writing one texel per cycle to all MAP_WIDTH *
// MAP_HEIGHT texels (65536 at 256 x 256); requests are stalled during that time.
// An add-light request scans every texel at one texel per cycle through a single
// pipeline (distance, 24-stage square root, 17-stage divider, multiply, read-modify-write
// on the map memory), then waits for the pipeline to empty. A read passes through the
// memory read port in ST_READ and ST_RCAP, then goes to the response register.
// One request is in work at a time; req_stall is high while busy. A finished result
// sits in the response register until taken, so a stalled receiver holds only the next
// result back, not the next request.
`default_nettype none

module radial_light_splat_lightmap import rlsl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        operation,
  input  logic [15:0] center_x,
  input  logic [15:0] center_y,
  input  logic [15:0] light_radius,
  input  logic [8:0]  light_strength,
  input  logic [15:0] texel_index,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  level,
  output logic        was_read
);

  state_t              state, state_next;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [DRAIN_W-1:0]  drain_cnt;
  logic [15:0]         radius_q;
  logic [8:0]          strength_q;
  logic [ADDR_W-1:0]   idx_q;
  logic                in_range_q;
  logic [7:0]          res_level;
  logic                res_read;

  logic [15:0]         radius_eff;
  logic [31:0]         idx_ext;
  logic                accept;
  logic                start;
  logic                clr_en;
  logic                rd_en;
  logic                load_rsp;

  logic                sweep_busy;
  tag_t                sw_tag, sq_tag, dv_tag;
  logic [31:0]         dist2;
  logic [SQRT_W-1:0]   dist_root;
  logic [QUO_W-1:0]    v;
  logic [7:0]          rd_data;

  assign radius_eff = (light_radius == 16'd0) ? 16'd1 : light_radius;
  assign idx_ext    = 32'(texel_index);
  assign accept     = req_valid && !req_stall;

  always_comb begin
    req_stall = (state != ST_IDLE);
    start     = (state == ST_IDLE) && req_valid && (operation == OP_ADD);
    clr_en    = (state == ST_CLEAR);
    rd_en     = (state == ST_READ);
    load_rsp  = (state == ST_RESP) && (!rsp_valid || !rsp_stall);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(TEXELS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = (operation == OP_READ) ? ST_READ : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (!sweep_busy) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_cnt == '1) state_next = ST_RESP;
      end
      ST_READ: begin
        state_next = ST_RCAP;
      end
      ST_RCAP: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (load_rsp) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      drain_cnt <= '0;
    end else begin
      state <= state_next;
      if (clr_en) clr_cnt <= clr_cnt + 1'b1;
      drain_cnt <= (state == ST_DRAIN) ? drain_cnt + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      radius_q   <= radius_eff;
      strength_q <= light_strength;
      idx_q      <= idx_ext[ADDR_W-1:0];
      in_range_q <= idx_ext < 32'(TEXELS);
      res_level  <= 8'd0;
      res_read   <= (operation == OP_READ);
    end else if (state == ST_RCAP) begin
      res_level <= in_range_q ? rd_data : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
      level     <= res_level;
      was_read  <= res_read;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  rlsl_sweep u_sweep (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius_eff),
    .busy     (sweep_busy),
    .tag_out  (sw_tag),
    .dist2    (dist2)
  );

  rlsl_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (sw_tag),
    .dist2   (dist2),
    .tag_out (sq_tag),
    .root    (dist_root)
  );

  rlsl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (sq_tag),
    .dist_root (dist_root),
    .divisor   (radius_q),
    .tag_out   (dv_tag),
    .quo       (v)
  );

  rlsl_lmem u_lmem (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (dv_tag),
    .v        (v),
    .strength (strength_q),
    .clr_en   (clr_en),
    .clr_addr (clr_cnt),
    .rd_en    (rd_en),
    .rd_addr  (idx_q),
    .rd_data  (rd_data)
  );

endmodule

`default_nettype wire
